// ===== rtl/core/gbn_pkg.sv =====
// Package for the go-back-n sender window: widths, codes and helpers.
package gbn_pkg;

  // Sequence number width and derived sizes
  localparam int SeqBits  = 4;
  localparam int SeqDepth = 1 << SeqBits;

  localparam logic [SeqBits-1:0] SeqMax = {SeqBits{1'b1}};
  localparam logic [15:0] TimerMax      = 16'hFFFF;
  localparam logic [15:0] TimeoutReset  = 16'd2000;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_SEND = 2'd2,
    KIND_NOP  = 2'd3
  } kind_e;

  // Result actions
  typedef enum logic [2:0] {
    ACT_IDLE    = 3'd0,
    ACT_SENT    = 3'd1,
    ACT_RETX    = 3'd2,
    ACT_ACK_OK  = 3'd3,
    ACT_ACK_IGN = 3'd4,
    ACT_FULL    = 3'd5
  } action_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_EXEC,
    ST_READ,
    ST_RETX,
    ST_OUT
  } state_e;

  // Sequence number to the 4-bit output fields (zero extend or truncate)
  function automatic logic [3:0] seq_to_out(logic [SeqBits-1:0] s);
    logic [SeqBits+3:0] w;
    w = {4'b0000, s};
    return w[3:0];
  endfunction

  // 4-bit input number to a sequence number
  function automatic logic [SeqBits-1:0] in_to_seq(logic [3:0] a);
    logic [SeqBits+3:0] w;
    w = {{SeqBits{1'b0}}, a};
    return w[SeqBits-1:0];
  endfunction

endpackage

// ===== rtl/core/go_back_n_sender_window.sv =====
// Go-back-n sender window: sequencer, shared modulo subtractor, handle store.
//
//  channel | signals                                      | dir | accepted when
//  --------+----------------------------------------------+-----+----------------------
//  in      | in_valid_i, in_stall_o, kind_i, ack_number_i,| in  | in_valid_i & !in_stall_o
//          | frame_handle_i                               |     |
//  out     | out_valid_o, out_stall_i, action_o,          | out | out_valid_o & !out_stall_i
//          | sequence_res_o, handle_out_o, in_flight_o,   |     |
//          | last_o                                       |     |
//  cfg     | cfg_we_i, cfg_wdata_i (timeout_ticks)        | in  | cfg_we_i
//
// A request passes through accept, outstanding count and decision (both through
// the one shared modulo subtractor), then the result, which waits for the output.
// In a timeout run each frame goes through handle store read, result and hand-off,
// as the store read port is registered; a frame starts after the previous hand-off.
// Reset clears window pointers, timer and sequencer; the handle store is not
// cleared. in_stall_o is high from acceptance until the last result is taken.
module go_back_n_sender_window
  import gbn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  ack_number_i,
  input  logic [7:0]  frame_handle_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [3:0]  sequence_res_o,
  output logic [7:0]  handle_out_o,
  output logic [3:0]  in_flight_o,
  output logic        last_o
);

  state_e state_q, state_d;

  logic [15:0]        timeout_q;
  logic [SeqBits-1:0] base_q, base_d;
  logic [SeqBits-1:0] next_q, next_d;
  logic [15:0]        timer_q, timer_d;
  logic               active_q, active_d;

  // latched request
  kind_e              kind_q;
  logic [SeqBits-1:0] ack_q;
  logic [7:0]         handle_q;

  logic [SeqBits-1:0] n_q;      // outstanding count
  logic [SeqBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [7:0]         rdata_q;

  // output registers
  action_e            act_q, act_d;
  logic [3:0]         seq_out_q, seq_out_d;
  logic [7:0]         hnd_out_q, hnd_out_d;
  logic [3:0]         flt_out_q, flt_out_d;
  logic               last_q, last_d;

  // handle store
  logic [7:0]         mem [SeqDepth];
  logic               mem_we;

  // shared modulo subtractor
  logic [SeqBits-1:0] alu_a, alu_b, alu_diff;

  always_comb begin
    if (state_q == ST_COUNT) begin
      alu_a = next_q;
    end else begin
      alu_a = ack_q;
    end
    alu_b    = base_q;
    alu_diff = alu_a - alu_b;
  end

  // decision terms used in the execute step, plus retransmit-run and handshake terms
  logic [15:0]        timer_inc;
  logic               timeout_hit;
  logic               ack_in_win;
  logic               win_full;
  logic [SeqBits-1:0] rd_nxt;
  logic               accept_in, accept_out, run_last;

  always_comb begin
    timer_inc   = (timer_q == TimerMax) ? timer_q : timer_q + 16'd1;
    timeout_hit = active_q && (timer_inc > timeout_q);
    ack_in_win  = (alu_diff != '0) && (alu_diff <= n_q);
    win_full    = (n_q == SeqMax);
    rd_nxt      = rd_ptr_q + 1'b1;
    run_last    = (rd_nxt == next_q);
    accept_in   = in_valid_i && !in_stall_o;
    accept_out  = out_valid_o && !out_stall_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept_in) state_d = ST_COUNT;
      ST_COUNT: state_d = ST_EXEC;
      ST_EXEC: begin
        if (kind_q == KIND_TICK && timeout_hit && n_q != '0) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_READ:  state_d = ST_RETX;
      ST_RETX:  state_d = ST_OUT;
      ST_OUT: begin
        if (accept_out) begin
          if (act_q == ACT_RETX && !last_q) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and result values
  always_comb begin
    base_d    = base_q;
    next_d    = next_q;
    timer_d   = timer_q;
    active_d  = active_q;
    rd_ptr_d  = rd_ptr_q;
    mem_we    = 1'b0;
    act_d     = act_q;
    seq_out_d = seq_out_q;
    hnd_out_d = hnd_out_q;
    flt_out_d = flt_out_q;
    last_d    = last_q;
    case (state_q)
      ST_EXEC: begin
        act_d     = ACT_IDLE;
        seq_out_d = 4'd0;
        hnd_out_d = 8'd0;
        flt_out_d = seq_to_out(n_q);
        last_d    = 1'b1;
        rd_ptr_d  = base_q;
        case (kind_q)
          KIND_TICK: begin
            if (active_q) begin
              timer_d = timeout_hit ? 16'd0 : timer_inc;
            end
          end
          KIND_ACK: begin
            if (ack_in_win) begin
              base_d    = ack_q;
              timer_d   = 16'd0;
              if (ack_q == next_q) active_d = 1'b0;
              act_d     = ACT_ACK_OK;
              flt_out_d = seq_to_out(n_q - alu_diff);
            end else begin
              act_d = ACT_ACK_IGN;
            end
          end
          KIND_SEND: begin
            if (win_full) begin
              act_d = ACT_FULL;
            end else begin
              mem_we    = 1'b1;
              next_d    = next_q + 1'b1;
              if (!active_q) begin
                active_d = 1'b1;
                timer_d  = 16'd0;
              end
              act_d     = ACT_SENT;
              seq_out_d = seq_to_out(next_q);
              hnd_out_d = handle_q;
              flt_out_d = seq_to_out(n_q + 1'b1);
            end
          end
          default: ;
        endcase
      end
      ST_RETX: begin
        act_d     = ACT_RETX;
        seq_out_d = seq_to_out(rd_ptr_q);
        hnd_out_d = rdata_q;
        flt_out_d = seq_to_out(n_q);
        last_d    = run_last;
      end
      ST_OUT: begin
        if (accept_out && act_q == ACT_RETX && !last_q) rd_ptr_d = rd_nxt;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      timeout_q <= TimeoutReset;
      base_q    <= '0;
      next_q    <= '0;
      timer_q   <= 16'd0;
      active_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      base_q    <= base_d;
      next_q    <= next_d;
      timer_q   <= timer_d;
      active_q  <= active_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      kind_q   <= kind_e'(kind_i);
      ack_q    <= in_to_seq(ack_number_i);
      handle_q <= frame_handle_i;
    end
    if (state_q == ST_COUNT) n_q <= alu_diff;
    rd_ptr_q  <= rd_ptr_d;
    act_q     <= act_d;
    seq_out_q <= seq_out_d;
    hnd_out_q <= hnd_out_d;
    flt_out_q <= flt_out_d;
    last_q    <= last_d;
  end

  // handle store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[next_q] <= handle_q;
    if (state_q == ST_READ) rdata_q <= mem[rd_ptr_q];
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = (state_q == ST_OUT);
  assign action_o       = act_q;
  assign sequence_res_o = seq_out_q;
  assign handle_out_o   = hnd_out_q;
  assign in_flight_o    = flt_out_q;
  assign last_o         = last_q;

  // checks
  a_stall_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while a result is pending");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && act_q != ACT_RETX) |-> last_q)
    else $error("single result without last");

  a_timer_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (active_q == (next_q != base_q)))
    else $error("timer state disagrees with window occupancy");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> (state_q == ST_COUNT))
    else $error("sequencer did not start on request");

endmodule

// ===== sim/go_back_n_sender_window_checker.sv =====
// Checker for the go-back-n sender window: tracks the window, predicts results and compares them.
module go_back_n_sender_window_checker
  import gbn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  ack_number_i,
  input  logic [7:0]  frame_handle_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  action_i,
  input  logic [3:0]  sequence_res_i,
  input  logic [7:0]  handle_out_i,
  input  logic [3:0]  in_flight_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          retx_o
);

  typedef struct packed {
    action_e    action;
    logic [3:0] seq;
    logic [7:0] handle;
    logic [3:0] flight;
    logic       last;
  } window_result_t;

  // Results owed by the block, oldest first
  window_result_t awaited_results[$];

  // Shadow window state
  logic [15:0] timeout_ticks_q;
  logic [3:0]  base_q;
  logic [3:0]  next_q;
  logic [7:0]  handle_store [16];
  logic [15:0] timer_q;
  logic        timer_on_q;

  int fails     = 0;
  int seen      = 0;
  int retx_seen = 0;

  function automatic window_result_t make_result(action_e act, logic [3:0] seq,
                                                 logic [7:0] hnd, logic [3:0] flight,
                                                 logic fin);
    window_result_t r;
    r.action = act;
    r.seq    = seq;
    r.handle = hnd;
    r.flight = flight;
    r.last   = fin;
    return r;
  endfunction

  // Append one expectation at the tail of the queue
  function automatic void owe_result(window_result_t r);
    awaited_results = {awaited_results, r};
  endfunction

  // Work out the results of one accepted request and advance the shadow window
  task automatic predict_window(logic [1:0] kind, logic [3:0] ack, logic [7:0] hnd);
    logic [3:0] flight;
    logic [3:0] ack_span;
    logic [3:0] s;
    bit         fired;
    int         i;
    flight = next_q - base_q;
    fired  = 1'b0;
    case (kind)
      KIND_TICK: begin
        if (timer_on_q) begin
          // timer saturates instead of wrapping
          if (timer_q != TimerMax) timer_q = timer_q + 16'd1;
          if (timer_q > timeout_ticks_q) begin
            timer_q = '0;
            if (flight != 4'd0) begin
              fired = 1'b1;
              s = base_q;
              for (i = 0; i < flight; i++) begin
                owe_result(make_result(ACT_RETX, s, handle_store[s], flight,
                                       (i + 1 == flight)));
                s = s + 4'd1;
              end
            end
          end
        end
        if (!fired) owe_result(make_result(ACT_IDLE, '0, '0, flight, 1'b1));
      end
      KIND_ACK: begin
        // cumulative ack must land in (base, next]
        ack_span = ack - base_q;
        if (ack_span != 4'd0 && ack_span <= flight) begin
          base_q  = ack;
          timer_q = '0;
          if (base_q == next_q) timer_on_q = 1'b0;
          owe_result(make_result(ACT_ACK_OK, '0, '0, next_q - base_q, 1'b1));
        end else begin
          owe_result(make_result(ACT_ACK_IGN, '0, '0, flight, 1'b1));
        end
      end
      KIND_SEND: begin
        if (flight == SeqMax) begin
          owe_result(make_result(ACT_FULL, '0, '0, flight, 1'b1));
        end else begin
          s = next_q;
          handle_store[s] = hnd;
          next_q = next_q + 4'd1;
          if (!timer_on_q) begin
            timer_on_q = 1'b1;
            timer_q    = '0;
          end
          owe_result(make_result(ACT_SENT, s, hnd, next_q - base_q, 1'b1));
        end
      end
      default: begin
        owe_result(make_result(ACT_IDLE, '0, '0, flight, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fails++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic compare_result();
    window_result_t want;
    seen++;
    if (action_i == ACT_RETX) retx_seen++;
    if (awaited_results.size() == 0) begin
      fails++;
      $error("unexpected result: action %0d with nothing outstanding", action_i);
    end else begin
      want = awaited_results.pop_front();
      check_field("action", want.action, action_i);
      check_field("sequence_res", want.seq, sequence_res_i);
      check_field("handle_out", want.handle, handle_out_i);
      check_field("in_flight", want.flight, in_flight_i);
      check_field("last", want.last, last_i);
    end
  endtask

  // Results are compared before the same-edge request is predicted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      timeout_ticks_q = TimeoutReset;
      base_q          = '0;
      next_q          = '0;
      timer_q         = '0;
      timer_on_q      = 1'b0;
      awaited_results.delete();
    end else begin
      if (cfg_we_i) timeout_ticks_q = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) compare_result();
      if (in_valid_i && !in_stall_i) predict_window(kind_i, ack_number_i, frame_handle_i);
    end
    pending_o    <= awaited_results.size();
    fail_count_o <= fails;
    results_o    <= seen;
    retx_o       <= retx_seen;
  end

endmodule

// ===== sim/tb_go_back_n_sender_window.sv =====
// Testbench top for the go-back-n sender window: request stimulus, watchdog and verdict.
module tb_go_back_n_sender_window;
  import gbn_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 8;
  localparam int TailCycles    = 20;
  localparam int HoldTicks     = 4;
  localparam int RandomPhases  = 6;
  localparam int PhaseItems    = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic [1:0]  kind_i;
  logic [3:0]  ack_number_i;
  logic [7:0]  frame_handle_i;
  logic        out_stall_i = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [2:0]  action_o;
  logic [3:0]  sequence_res_o;
  logic [7:0]  handle_out_o;
  logic [3:0]  in_flight_o;
  logic        last_o;

  int fail_count;
  int pending;
  int results;
  int retx;
  int idle_cycles   = 0;
  int sent_items    = 0;
  int settings_used = 0;
  bit calm          = 1'b0;

  // Window pointers as seen from the request side, for well-formed acks
  logic [3:0] shadow_base = '0;
  logic [3:0] shadow_next = '0;

  always #1 clk_i = ~clk_i;

  go_back_n_sender_window uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .ack_number_i   (ack_number_i),
    .frame_handle_i (frame_handle_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .sequence_res_o (sequence_res_o),
    .handle_out_o   (handle_out_o),
    .in_flight_o    (in_flight_o),
    .last_o         (last_o)
  );

  go_back_n_sender_window_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .kind_i         (kind_i),
    .ack_number_i   (ack_number_i),
    .frame_handle_i (frame_handle_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_i       (action_o),
    .sequence_res_i (sequence_res_o),
    .handle_out_i   (handle_out_o),
    .in_flight_i    (in_flight_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results),
    .retx_o         (retx)
  );

  // Random back-pressure on the result side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 37);
    end
  end

  // Cycles without any handshake or register write
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("timeout: no handshake for %0d cycles", WatchdogLimit);
    $display("FAIL go_back_n_sender_window");
    $finish;
  end

  function automatic int draw_gap();
    int g;
    g = 0;
    if (!calm) begin
      while ($urandom_range(99) < 37) g++;
    end
    return g;
  endfunction

  // Offer one request and hold it until accepted
  task automatic push_request(logic [1:0] kind, logic [3:0] ack, logic [7:0] hnd);
    int         gap;
    logic [3:0] flight;
    logic [3:0] ack_span;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    ack_number_i   <= ack;
    frame_handle_i <= hnd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    flight   = shadow_next - shadow_base;
    ack_span = ack - shadow_base;
    if (kind == KIND_SEND && flight != SeqMax) begin
      shadow_next = shadow_next + 4'd1;
    end else if (kind == KIND_ACK && ack_span != 4'd0 && ack_span <= flight) begin
      shadow_base = ack;
    end
    sent_items++;
  endtask

  // Stop offering requests until every expected result is in
  task automatic drain_window();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] ticks);
    drain_window();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Mostly sends, ticks and in-window acks, with some stale acks and no-ops
  task automatic random_request();
    int         pick;
    int         sel;
    logic [3:0] flight;
    logic [3:0] ack;
    flight = shadow_next - shadow_base;
    pick   = $urandom_range(99);
    if (pick < 38) begin
      push_request(KIND_SEND, 4'($urandom_range(15)), 8'($urandom_range(255)));
    end else if (pick < 70) begin
      push_request(KIND_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
    end else if (pick < 94) begin
      sel = $urandom_range(99);
      if (flight != 4'd0 && sel < 70) begin
        ack = 4'($urandom_range(flight, 1));
        ack = ack + shadow_base;
      end else if (sel < 85) begin
        ack = shadow_base;
      end else begin
        ack = 4'($urandom_range(15));
      end
      push_request(KIND_ACK, ack, 8'($urandom_range(255)));
    end else begin
      push_request(KIND_NOP, 4'($urandom_range(15)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int phase;
    int n;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    kind_i         <= KIND_TICK;
    ack_number_i   <= '0;
    frame_handle_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty window, no-op, acks at and beyond the window, full ack
    push_request(KIND_TICK, 4'h0, 8'h00);
    push_request(KIND_ACK, 4'hF, 8'hFF);
    push_request(KIND_NOP, 4'hF, 8'hFF);
    push_request(KIND_SEND, 4'hF, 8'h00);
    push_request(KIND_SEND, 4'h0, 8'hFF);
    push_request(KIND_ACK, shadow_base, 8'h00);
    push_request(KIND_ACK, 4'd9, 8'h00);
    push_request(KIND_ACK, shadow_next, 8'h00);

    // Directed: fill the window, refuse one more, retransmit all, wrapped ack
    write_timeout(16'd0);
    repeat (15) push_request(KIND_SEND, 4'($urandom_range(15)), 8'($urandom_range(255)));
    push_request(KIND_SEND, 4'h0, 8'h5A);
    push_request(KIND_TICK, 4'h0, 8'h00);
    push_request(KIND_ACK, shadow_next, 8'h00);

    // Timer under the never-firing limit keeps counting, then fires once the limit drops
    write_timeout(16'hFFFF);
    calm = 1'b1;
    push_request(KIND_SEND, 4'h0, 8'hC3);
    repeat (HoldTicks) push_request(KIND_TICK, 4'h0, 8'h00);
    write_timeout(16'd2);
    push_request(KIND_TICK, 4'h0, 8'h00);
    push_request(KIND_ACK, shadow_next, 8'h00);
    calm = 1'b0;

    // Random phases over several timeouts; one phase without idling
    for (phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0:       write_timeout(16'd1);
        1:       write_timeout(16'd65534);
        3:       write_timeout(TimeoutReset);
        default: write_timeout(16'($urandom_range(8, 2)));
      endcase
      calm = (phase == 2);
      for (n = 0; n < PhaseItems; n++) begin
        random_request();
        if (n == PhaseItems / 2 || $urandom_range(19) == 0) drain_window();
      end
    end
    calm = 1'b0;

    drain_window();
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d requests, %0d results (%0d retransmissions), %0d timeout settings,",
             sent_items, results, retx, settings_used);
    $display("with window-full refusals, wrapped acks and a timeout limit that never fires.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS go_back_n_sender_window");
    end else begin
      $display("FAIL go_back_n_sender_window");
    end
    $finish;
  end

endmodule
